FILE: sv/nkts_pkg.sv
// Package for the nucleotide k-mer trim scanner.
// Holds widths, character codes and limits; no dependencies.
package nkts_pkg;

    localparam int MAX_SEQ_LEN = 65536;
    localparam int POS_W       = 16;            // character offsets
    localparam int IDX_W       = 17;            // counts up to MAX_SEQ_LEN
    localparam int KMER_W      = 7;
    localparam int CNT_W       = 16;

    localparam logic [KMER_W-1:0] KMER_RESET = 7'd31;
    localparam logic [KMER_W-1:0] RUN_MAX    = 7'd127;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;
    localparam logic [IDX_W-1:0]  IDX_LIMIT  = IDX_W'(MAX_SEQ_LEN);

    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] CHAR_U      = 8'h55;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

endpackage

FILE: sv/nucleotide_kmer_trim_scanner.sv
// Top level of the nucleotide k-mer trim scanner.
// Depends on nkts_pkg.
//
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// char     | char_valid / char_stall    | char_in, last_char
// result   | result_valid / result_stall| char_out, summary_valid, trim_start,
//          |                            | kept_length, keep_sequence, u_count,
//          |                            | invalid_count, length_overflow
// cfg      | cfg_valid / cfg_ready      | cfg_data (kmer_length)
//
// One character per cycle while char_stall is low; each result is registered and appears in the cycle after its beat.
// The scan state and the result register are updated in the same cycle, so
// back-to-back beats need no bubbles. char_stall is raised only while a
// result is held and result_stall is high. Reset clears the scan state and
// loads k = 31; the state also clears after every last character.
module nucleotide_kmer_trim_scanner
    import nkts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  logic [7:0]          char_in,
    input  logic                last_char,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [7:0]          char_out,
    output logic                summary_valid,
    output logic [POS_W-1:0]    trim_start,
    output logic [IDX_W-1:0]    kept_length,
    output logic                keep_sequence,
    output logic [CNT_W-1:0]    u_count,
    output logic [CNT_W-1:0]    invalid_count,
    output logic                length_overflow,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [KMER_W-1:0]   cfg_data
);

    logic [KMER_W-1:0] kmer_reg;
    logic [KMER_W-1:0] run_reg, run_next;
    logic              found_reg, found_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  end_reg, end_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [CNT_W-1:0]  useen_reg, useen_next;
    logic [CNT_W-1:0]  inval_reg, inval_next;
    logic              ovf_reg, ovf_next;

    logic              rvalid_reg;
    logic [7:0]        cout_reg, cout_next;
    logic              sum_reg;
    logic [POS_W-1:0]  tstart_reg, tstart_next;
    logic [IDX_W-1:0]  kept_reg, kept_next;
    logic              keep_reg, keep_next;
    logic [CNT_W-1:0]  ucnt_reg, inv_reg;
    logic              lovf_reg;

    logic              accept;
    logic [7:0]        c_up;
    logic              is_u;
    logic              is_nt;
    logic [KMER_W-1:0] k_eff;
    logic [POS_W-1:0]  pos;

    assign cfg_ready  = 1'b1;
    assign char_stall = rvalid_reg & result_stall;
    assign accept     = char_valid & ~char_stall;

    always_comb
    begin
        c_up  = ((char_in >= LOWER_A) && (char_in <= LOWER_Z)) ? char_in - CASE_OFFSET
                                                                : char_in;
        is_u  = (c_up == CHAR_U);
        is_nt = (c_up == CHAR_A) || (c_up == CHAR_C) || (c_up == CHAR_G) ||
                (c_up == CHAR_T) || is_u;
        cout_next = is_u ? CHAR_T : c_up;
        k_eff = (kmer_reg == '0) ? KMER_W'(1) : kmer_reg;
        pos   = index_reg[POS_W-1:0];

        useen_next = useen_reg + CNT_W'(is_u && (useen_reg != CNT_MAX));
        inval_next = inval_reg + CNT_W'(!is_nt && (inval_reg != CNT_MAX));

        run_next   = run_reg;
        found_next = found_reg;
        start_next = start_reg;
        end_next   = end_reg;
        index_next = index_reg;
        ovf_next   = ovf_reg;

        if (index_reg != IDX_LIMIT)
        begin
            index_next = index_reg + IDX_W'(1);
            if (!is_nt)
            begin
                run_next = '0;
            end
            else
            begin
                run_next = (run_reg != RUN_MAX) ? run_reg + KMER_W'(1) : run_reg;
                if (run_next >= k_eff)
                begin
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        // run covers pos-k+1..pos, so this never wraps
                        start_next = pos + POS_W'(1) - POS_W'(k_eff);
                    end
                    end_next = pos;
                end
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end

        // no k-mer found: whole sequence is kept
        if (found_next)
        begin
            tstart_next = start_next;
            kept_next   = IDX_W'(end_next) + IDX_W'(1) - IDX_W'(start_next);
        end
        else
        begin
            tstart_next = '0;
            kept_next   = index_next;
        end
        keep_next = (kept_next >= IDX_W'(k_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_reg  <= KMER_RESET;
            run_reg   <= '0;
            found_reg <= 1'b0;
            start_reg <= '0;
            end_reg   <= '0;
            index_reg <= '0;
            useen_reg <= '0;
            inval_reg <= '0;
            ovf_reg   <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                kmer_reg <= cfg_data;
            end
            if (accept)
            begin
                if (last_char)
                begin
                    run_reg   <= '0;
                    found_reg <= 1'b0;
                    start_reg <= '0;
                    end_reg   <= '0;
                    index_reg <= '0;
                    useen_reg <= '0;
                    inval_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    run_reg   <= run_next;
                    found_reg <= found_next;
                    start_reg <= start_next;
                    end_reg   <= end_next;
                    index_reg <= index_next;
                    useen_reg <= useen_next;
                    inval_reg <= inval_next;
                    ovf_reg   <= ovf_next;
                end
                rvalid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                rvalid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only on an accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cout_reg   <= cout_next;
            sum_reg    <= last_char;
            tstart_reg <= last_char ? tstart_next : '0;
            kept_reg   <= last_char ? kept_next : '0;
            keep_reg   <= last_char & keep_next;
            ucnt_reg   <= last_char ? useen_next : '0;
            inv_reg    <= last_char ? inval_next : '0;
            lovf_reg   <= last_char & ovf_next;
        end
    end

    assign result_valid    = rvalid_reg;
    assign char_out        = cout_reg;
    assign summary_valid   = sum_reg;
    assign trim_start      = tstart_reg;
    assign kept_length     = kept_reg;
    assign keep_sequence   = keep_reg;
    assign u_count         = ucnt_reg;
    assign invalid_count   = inv_reg;
    assign length_overflow = lovf_reg;

endmodule

FILE: sv/nkts_checker.sv
// Port-level checker for nucleotide_kmer_trim_scanner, with its bind.
// Depends on nkts_pkg and the top level's port list.
module nkts_checker
    import nkts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_stall,
    input  logic                result_valid,
    input  logic                result_stall,
    input  logic [7:0]          char_out,
    input  logic                summary_valid,
    input  logic [POS_W-1:0]    trim_start,
    input  logic [IDX_W-1:0]    kept_length,
    input  logic                keep_sequence,
    input  logic [CNT_W-1:0]    u_count,
    input  logic [CNT_W-1:0]    invalid_count,
    input  logic                length_overflow
);

    // held result beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(char_out) && $stable(summary_valid) &&
            $stable(kept_length))
        else $error("stalled result beat changed");

    // input is only stalled while a result is held
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> result_valid && result_stall)
        else $error("char_stall without a held result");

    // non-summary beats carry zero summary fields
    a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !summary_valid |->
            trim_start == '0 && kept_length == '0 && !keep_sequence &&
            u_count == '0 && invalid_count == '0 && !length_overflow)
        else $error("summary fields set on a plain beat");

    // output is never lower case and never U
    a_case: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> char_out != CHAR_U && (char_out < LOWER_A || char_out > LOWER_Z))
        else $error("char_out not normalized");

    // kept window stays within the sequence
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && summary_valid |->
            (IDX_W + 1)'(trim_start) + (IDX_W + 1)'(kept_length) <= (IDX_W + 1)'(MAX_SEQ_LEN))
        else $error("kept window past maximum length");

endmodule

bind nucleotide_kmer_trim_scanner nkts_checker u_nkts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .char_stall      (char_stall),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .char_out        (char_out),
    .summary_valid   (summary_valid),
    .trim_start      (trim_start),
    .kept_length     (kept_length),
    .keep_sequence   (keep_sequence),
    .u_count         (u_count),
    .invalid_count   (invalid_count),
    .length_overflow (length_overflow)
);

FILE: sim/tb_top.sv
// Self-checking testbench for nucleotide_kmer_trim_scanner.
// Scores every result beat against an in-bench scan model; needs only nkts_pkg and the RTL.
module tb_top;
    import nkts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;   // cycles with no beat on any channel
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_BUDGET = 165; // characters per k setting

    typedef struct packed {
        logic [7:0]       ch;
        logic             summ;
        logic [POS_W-1:0] tstart;
        logic [IDX_W-1:0] kept;
        logic             keep;
        logic [CNT_W-1:0] ucnt;
        logic [CNT_W-1:0] icnt;
        logic             ovf;
    } scan_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              char_valid = 1'b0;
    logic              char_stall;
    logic [7:0]        char_in = '0;
    logic              last_char = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [7:0]        char_out;
    logic              summary_valid;
    logic [POS_W-1:0]  trim_start;
    logic [IDX_W-1:0]  kept_length;
    logic              keep_sequence;
    logic [CNT_W-1:0]  u_count;
    logic [CNT_W-1:0]  invalid_count;
    logic              length_overflow;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [KMER_W-1:0] cfg_data = '0;

    // scan model state
    logic [KMER_W-1:0] k_reg = KMER_RESET;
    logic [KMER_W-1:0] run_len = '0;
    logic              kmer_started = 1'b0;
    logic [POS_W-1:0]  kmer_first = '0;
    logic [POS_W-1:0]  kmer_last = '0;
    logic [IDX_W-1:0]  seq_pos = '0;
    logic [CNT_W-1:0]  u_total = '0;
    logic [CNT_W-1:0]  bad_total = '0;
    logic              too_long = 1'b0;

    scan_result_t pending_results[$];

    int n_chars = 0;
    int n_seqs = 0;
    int n_results = 0;
    int n_errors = 0;
    bit no_gaps = 1'b0;
    int hold_cycles = 0;

    logic any_beat;
    assign any_beat = (char_valid && !char_stall) || (result_valid && !result_stall)
                   || (cfg_valid && cfg_ready);

    nucleotide_kmer_trim_scanner dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_valid      (char_valid),
        .char_stall      (char_stall),
        .char_in         (char_in),
        .last_char       (last_char),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .char_out        (char_out),
        .summary_valid   (summary_valid),
        .trim_start      (trim_start),
        .kept_length     (kept_length),
        .keep_sequence   (keep_sequence),
        .u_count         (u_count),
        .invalid_count   (invalid_count),
        .length_overflow (length_overflow),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advances the scan model by one character and returns the result it owes.
    function automatic scan_result_t scan_char(logic [7:0] raw, logic last);
        scan_result_t      r;
        logic [7:0]        c;
        logic [KMER_W-1:0] k;
        logic              is_nt;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  span;
        k = (k_reg == '0) ? KMER_W'(1) : k_reg;
        c = raw;
        if (c >= LOWER_A && c <= LOWER_Z)
            c = c - CASE_OFFSET;
        is_nt = (c == CHAR_A) || (c == CHAR_C) || (c == CHAR_G) || (c == CHAR_T)
             || (c == CHAR_U);
        if (c == CHAR_U)
        begin
            c = CHAR_T;
            if (u_total != CNT_MAX)
                u_total = u_total + 1'b1;
        end
        if (!is_nt && bad_total != CNT_MAX)
            bad_total = bad_total + 1'b1;

        // characters past the length limit only feed the counters
        if (seq_pos < IDX_LIMIT)
        begin
            pos = seq_pos;
            seq_pos = seq_pos + 1'b1;
            if (!is_nt)
                run_len = '0;
            else
            begin
                if (run_len != RUN_MAX)
                    run_len = run_len + 1'b1;
                if (run_len >= k)
                begin
                    if (!kmer_started)
                    begin
                        kmer_started = 1'b1;
                        kmer_first = POS_W'(pos + 1 - k);
                    end
                    kmer_last = pos[POS_W-1:0];
                end
            end
        end
        else
            too_long = 1'b1;

        r = '0;
        r.ch = c;
        if (last)
        begin
            // no k-mer at all: the whole sequence is kept
            if (kmer_started)
            begin
                r.tstart = kmer_first;
                span = IDX_W'({1'b0, kmer_last} + 1 - kmer_first);
            end
            else
                span = seq_pos;
            r.summ = 1'b1;
            r.kept = span;
            r.keep = (span >= k);
            r.ucnt = u_total;
            r.icnt = bad_total;
            r.ovf = too_long;
            run_len = '0;
            kmer_started = 1'b0;
            kmer_first = '0;
            kmer_last = '0;
            seq_pos = '0;
            u_total = '0;
            bad_total = '0;
            too_long = 1'b0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: result %0d: %s got 0x%0h, expected 0x%0h",
                 $time, n_results, what, got, want);
        n_errors++;
    endtask

    // Model update and result scoreboard; everything sampled at the rising edge.
    always @(posedge clk)
    begin : scoreboard
        scan_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                k_reg = cfg_data;
            if (char_valid && !char_stall)
            begin
                pending_results = {pending_results, scan_char(char_in, last_char)};
                n_chars++;
                if (last_char)
                    n_seqs++;
            end
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    flag_mismatch("result beat with nothing pending", char_out, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (char_out !== want.ch)
                        flag_mismatch("char_out", char_out, want.ch);
                    if (summary_valid !== want.summ)
                        flag_mismatch("summary_valid", summary_valid, want.summ);
                    if (trim_start !== want.tstart)
                        flag_mismatch("trim_start", trim_start, want.tstart);
                    if (kept_length !== want.kept)
                        flag_mismatch("kept_length", kept_length, want.kept);
                    if (keep_sequence !== want.keep)
                        flag_mismatch("keep_sequence", keep_sequence, want.keep);
                    if (u_count !== want.ucnt)
                        flag_mismatch("u_count", u_count, want.ucnt);
                    if (invalid_count !== want.icnt)
                        flag_mismatch("invalid_count", invalid_count, want.icnt);
                    if (length_overflow !== want.ovf)
                        flag_mismatch("length_overflow", length_overflow, want.ovf);
                end
            end
        end
    end

    // Result side: random stall before each beat, plus an optional long hold.
    initial
    begin : result_sink
        int gap;
        forever
        begin
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (any_beat)
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_results.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // Offers one character; returns at the edge where the beat is taken.
    // Valid stays high so the next call can follow with no bubble.
    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_valid <= 1'b1;
        char_in <= c;
        last_char <= last;
        do @(posedge clk); while (char_stall);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        char_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_kmer(logic [KMER_W-1:0] k);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= k;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text(string s, bit ends);
        for (int n = 0; n < s.len(); n++)
            send_char(s[n], ends && (n == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_char(int noise_pct);
        string bases;
        bases = "ACGTUacgtu";
        if ($urandom_range(0, 99) < noise_pct)
            return 8'($urandom_range(0, 255));
        return bases[$urandom_range(0, 9)];
    endfunction

    function automatic int pick_noise();
        case ($urandom_range(0, 4))
            0, 1:    return 0;
            2:       return 3;
            3:       return 15;
            default: return 50;
        endcase
    endfunction

    task automatic send_seq(int len, int noise_pct);
        for (int n = 0; n < len; n++)
            send_char(rand_char(noise_pct), n == len - 1);
    endtask

    // k = 31 out of reset: five bases are not enough for a k-mer
    task automatic test_default_kmer();
        send_text("ACGTA", 1'b1);
    endtask

    task automatic test_char_mapping();
        write_kmer(KMER_W'(2));
        send_text("ncGuTa", 1'b1);
        // just outside the letter ranges, then control and high bytes
        send_text("`{@[", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b1);
        send_text("zZaA", 1'b1);
    endtask

    task automatic test_zero_kmer();
        write_kmer('0);
        send_text("g", 1'b1);
    endtask

    // Sender stops in the middle of a sequence until every result is back.
    task automatic test_drain_mid_sequence();
        write_kmer(KMER_W'(4));
        send_text("acgtNAC", 1'b0);
        wait_drained();
        send_text("GTUU", 1'b1);
    endtask

    // Receiver holds off long enough for the block to stall its input.
    task automatic test_result_backpressure();
        write_kmer(KMER_W'(8));
        hold_cycles = 100;
        no_gaps = 1'b1;
        send_seq(60, 5);
        no_gaps = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_scan();
        logic [KMER_W-1:0] k_list [8];
        int budget;
        int len;
        int k_int;
        k_list = '{7'd31, 7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd0, 7'd100};
        k_list[6] = KMER_W'($urandom_range(3, 63));
        foreach (k_list[p])
        begin
            write_kmer(k_list[p]);
            k_int = (k_list[p] == '0) ? 1 : int'(k_list[p]);
            budget = 0;
            while (budget < RANDOM_BUDGET)
            begin
                // mostly lengths around k so runs reach it, some very short
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(1, 8);
                else
                    len = $urandom_range(k_int > 4 ? k_int - 4 : 1, 2 * k_int + 8);
                no_gaps = ($urandom_range(0, 3) == 0);
                send_seq(len, pick_noise());
                budget += len;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_kmer();
        test_char_mapping();
        test_zero_kmer();
        test_drain_mid_sequence();
        test_result_backpressure();
        test_random_scan();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Scanned %0d characters in %0d sequences, %0d result beats checked,",
                 n_chars, n_seqs, n_results);
        $display("k from 0 to 127, case mapping, high bytes, back-pressure, mid-sequence drain.");
        if (n_errors == 0 && pending_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
